[src/fid_pkg.sv]
// ----------------------------------------------------------------------------
// fid_pkg
// Shared types and constants of the free identifier stack allocator.
// ----------------------------------------------------------------------------
package fid_pkg;

    localparam int ID_COUNT = 1024;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int CNT_W    = $clog2(ID_COUNT + 1);

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_CHECK   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_RANGE  = 2'd2,
        STAT_DOUBLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Shift controls broadcast to every stack cell
    typedef struct packed {
        logic load;
        logic push;
        logic pop;
    } t_stk_ctrl;

endpackage

[src/fid_cell.sv]
// ----------------------------------------------------------------------------
// fid_cell
// One stack slot: loads its rebuild value, or shifts in from a neighbor.
// ----------------------------------------------------------------------------
module fid_cell (
    input  logic                       i_clk,
    input  fid_pkg::t_stk_ctrl         i_ctrl,
    input  logic [fid_pkg::ID_W-1:0]   i_init,
    input  logic [fid_pkg::ID_W-1:0]   i_from_above,
    input  logic [fid_pkg::ID_W-1:0]   i_from_below,
    output logic [fid_pkg::ID_W-1:0]   o_value
);

    logic [fid_pkg::ID_W-1:0] r_value;
    logic [fid_pkg::ID_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_init;
        end else if (i_ctrl.push) begin
            n_value = i_from_above;
        end else if (i_ctrl.pop) begin
            n_value = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[src/fid_stack.sv]
// ----------------------------------------------------------------------------
// fid_stack
// Systolic free stack: a row of cells, top of stack in cell 0.
// ----------------------------------------------------------------------------
module fid_stack (
    input  logic                        i_clk,
    input  fid_pkg::t_stk_ctrl          i_ctrl,
    input  logic [fid_pkg::CNT_W-1:0]   i_size,
    input  logic [fid_pkg::ID_W-1:0]    i_push_id,
    output logic [fid_pkg::ID_W-1:0]    o_top
);

    logic [fid_pkg::ID_W-1:0] w_val [fid_pkg::ID_COUNT];

    genvar k;
    generate
        for (k = 0; k < fid_pkg::ID_COUNT; k++) begin : g_cell
            logic [fid_pkg::CNT_W-1:0] w_init;
            logic [fid_pkg::ID_W-1:0]  w_above;
            logic [fid_pkg::ID_W-1:0]  w_below;

            // after rebuild cell k holds size-1-k; cells past the size are unused
            assign w_init = i_size - fid_pkg::CNT_W'(k + 1);

            if (k == 0) begin : g_first
                assign w_above = i_push_id;
            end else begin : g_mid
                assign w_above = w_val[k-1];
            end

            if (k == fid_pkg::ID_COUNT - 1) begin : g_last
                assign w_below = '0;
            end else begin : g_inner
                assign w_below = w_val[k+1];
            end

            fid_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (i_ctrl),
                .i_init       (w_init[fid_pkg::ID_W-1:0]),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_value      (w_val[k])
            );
        end
    endgenerate

    assign o_top = w_val[0];

endmodule

[src/fid_flag_ram.sv]
// ----------------------------------------------------------------------------
// fid_flag_ram
// Free flag memory, one bit per identifier, registered read.
// ----------------------------------------------------------------------------
module fid_flag_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [fid_pkg::ID_W-1:0]  i_waddr,
    input  logic                      i_wdata,
    input  logic [fid_pkg::ID_W-1:0]  i_raddr,
    output logic                      o_rdata
);

    logic r_mem [fid_pkg::ID_COUNT];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/free_id_stack_allocator.sv]
// ----------------------------------------------------------------------------
// free_id_stack_allocator
// Hands out identifiers from a LIFO free stack, keeps a free flag per id.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (i_command, i_number) is taken at a clock edge
//   where start is high and busy is low. Commands: get, check, release.
//   Result channel: o_done is high for one cycle with o_status,
//   o_granted_id and o_is_free; the receiver cannot stall it.
//   o_done is registered from the S_EXEC state entered at the accepting edge.
//   A new item is taken only after S_EXEC, as busy is high there; the flag
//   memory read of the accepting edge must return before the update cycle.
//   Config: i_pool_size is written when i_cfg_valid and o_cfg_ready are
//   high (o_cfg_ready is always high); write only while idle. A write
//   rebuilds the stack and the count and starts the flag clearing pass.
//   Reset (synchronous, i_rst_n low): pool size 1024, full stack, then a
//   clearing pass over every flag of the flag memory during which busy is high.
//   The same pass follows every configuration write.
// ----------------------------------------------------------------------------
module free_id_stack_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [fid_pkg::ID_W-1:0]      i_number,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fid_pkg::CNT_W-1:0]     i_pool_size,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [fid_pkg::ID_W-1:0]      o_granted_id,
    output logic                          o_is_free
);

    localparam logic [fid_pkg::CNT_W-1:0] FULL = fid_pkg::CNT_W'(fid_pkg::ID_COUNT);
    localparam logic [fid_pkg::ID_W-1:0]  LAST_ID = fid_pkg::ID_W'(fid_pkg::ID_COUNT - 1);

    fid_pkg::t_state r_state, n_state;

    logic [fid_pkg::CNT_W-1:0] r_size, n_size;
    logic [fid_pkg::CNT_W-1:0] r_count, n_count;
    logic [fid_pkg::ID_W-1:0]  r_clr_idx, n_clr_idx;
    fid_pkg::t_cmd             r_cmd;
    logic [fid_pkg::ID_W-1:0]  r_num;
    logic                      r_done, n_done;
    fid_pkg::t_status          r_status, n_status;
    logic [fid_pkg::ID_W-1:0]  r_granted, n_granted;
    logic                      r_is_free, n_is_free;

    logic                      w_cfg_wr;
    logic                      w_accept;
    logic [fid_pkg::CNT_W-1:0] w_cfg_size;
    logic [fid_pkg::CNT_W-1:0] w_load_size;
    fid_pkg::t_stk_ctrl        w_stk;
    logic [fid_pkg::ID_W-1:0]  w_top;
    logic                      w_flag;
    logic                      w_we;
    logic [fid_pkg::ID_W-1:0]  w_waddr;
    logic                      w_wdata;
    logic                      w_in_range;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign busy        = (r_state != fid_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign w_cfg_size  = (i_pool_size > FULL) ? FULL : i_pool_size;
    assign w_load_size = !i_rst_n ? FULL : w_cfg_size;
    assign w_in_range  = ({1'b0, r_num} < r_size);

    fid_stack u_stack (
        .i_clk     (i_clk),
        .i_ctrl    (w_stk),
        .i_size    (w_load_size),
        .i_push_id (r_num),
        .o_top     (w_top)
    );

    fid_flag_ram u_flags (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_number),
        .o_rdata (w_flag)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fid_pkg::S_CLEAR: begin
                if (r_clr_idx == LAST_ID) begin
                    n_state = fid_pkg::S_IDLE;
                end
            end
            fid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = fid_pkg::S_EXEC;
                end
            end
            fid_pkg::S_EXEC: begin
                n_state = fid_pkg::S_IDLE;
            end
            default: begin
                n_state = fid_pkg::S_CLEAR;
            end
        endcase
        if (w_cfg_wr) begin
            n_state = fid_pkg::S_CLEAR;
        end
    end

    // datapath and outputs
    always_comb begin
        n_size    = r_size;
        n_count   = r_count;
        n_clr_idx = r_clr_idx;
        n_done    = 1'b0;
        n_status  = fid_pkg::STAT_OK;
        n_granted = '0;
        n_is_free = 1'b0;
        w_stk     = '0;
        w_we      = 1'b0;
        w_waddr   = r_clr_idx;
        w_wdata   = 1'b1;

        case (r_state)
            fid_pkg::S_CLEAR: begin
                w_we      = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
            end
            fid_pkg::S_EXEC: begin
                n_done = 1'b1;
                case (r_cmd)
                    fid_pkg::CMD_GET: begin
                        if (r_count == '0) begin
                            n_status = fid_pkg::STAT_EMPTY;
                        end else begin
                            n_granted = w_top;
                            n_count   = r_count - 1'b1;
                            w_stk.pop = 1'b1;
                            w_we      = 1'b1;
                            w_waddr   = w_top;
                            w_wdata   = 1'b0;
                        end
                    end
                    fid_pkg::CMD_CHECK: begin
                        if (!w_in_range) begin
                            n_status = fid_pkg::STAT_RANGE;
                        end else begin
                            n_is_free = w_flag;
                        end
                    end
                    fid_pkg::CMD_RELEASE: begin
                        if (!w_in_range) begin
                            n_status = fid_pkg::STAT_RANGE;
                        end else if (w_flag) begin
                            n_status = fid_pkg::STAT_DOUBLE;
                        end else if (r_count < FULL) begin
                            n_count    = r_count + 1'b1;
                            w_stk.push = 1'b1;
                            w_we       = 1'b1;
                            w_waddr    = r_num;
                            w_wdata    = 1'b1;
                        end
                    end
                    default: begin
                        n_status = fid_pkg::STAT_OK;
                    end
                endcase
            end
            default: begin
                n_done = 1'b0;
            end
        endcase

        // rebuild on reset or pool size write
        if (!i_rst_n || w_cfg_wr) begin
            w_stk      = '0;
            w_stk.load = 1'b1;
        end
        if (w_cfg_wr) begin
            n_size    = w_cfg_size;
            n_count   = w_cfg_size;
            n_clr_idx = '0;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fid_pkg::S_CLEAR;
            r_size    <= FULL;
            r_count   <= FULL;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_count   <= n_count;
            r_clr_idx <= n_clr_idx;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= fid_pkg::t_cmd'(i_command);
            r_num <= i_number;
        end
        r_status  <= n_status;
        r_granted <= n_granted;
        r_is_free <= n_is_free;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_granted_id = r_granted;
    assign o_is_free    = r_is_free;

endmodule
